/* rtl/core/cpfd_pkg.sv */
// Package for the controller packet framer/decoder.
// Item field widths, framing characters, packet lengths and the struct between blocks.
// No dependencies.
package cpfd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned IDX_W  = 5;
   localparam int unsigned LEN_W  = 5;

   localparam logic [BYTE_W-1:0] CHAR_START = 8'h21;  // '!'
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CHAR_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_B     = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_C     = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_G     = 8'h47;
   localparam logic [BYTE_W-1:0] CHAR_L     = 8'h4C;
   localparam logic [BYTE_W-1:0] CHAR_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CHAR_Q     = 8'h51;

   localparam logic [LEN_W-1:0] LEN_MOTION = 5'd15;
   localparam logic [LEN_W-1:0] LEN_QUAT   = 5'd19;
   localparam logic [LEN_W-1:0] LEN_BUTTON = 5'd5;
   localparam logic [LEN_W-1:0] LEN_COLOR  = 5'd6;
   localparam logic [LEN_W-1:0] LEN_NONE   = 5'd0;

   localparam logic [BYTE_W-1:0] BUTTON_MAX = 8'd8;

   // Framer result for one item, handed to the decoder.
   typedef struct packed {
      logic              done;
      logic [BYTE_W-1:0] ptype;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] pay0;
      logic [BYTE_W-1:0] pay1;
      logic [BYTE_W-1:0] pay2;
   } frame_type;

   function automatic logic [LEN_W-1:0] expected_length(input logic [BYTE_W-1:0] t);
      logic [LEN_W-1:0] len;
      case (t) inside
         CHAR_A, CHAR_G, CHAR_M, CHAR_L: len = LEN_MOTION;
         CHAR_Q:                         len = LEN_QUAT;
         CHAR_B:                         len = LEN_BUTTON;
         CHAR_C:                         len = LEN_COLOR;
         default:                        len = LEN_NONE;
      endcase
      return len;
   endfunction

endpackage

/* rtl/core/cpfd_framer.sv */
// Framer: input register, packet index, start flag, type and payload capture.
// Flags completion of a packet on each item. Depends on cpfd_pkg.
module cpfd_framer #(
   parameter int unsigned BUFFER_DEPTH = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_take,
   input  logic [cpfd_pkg::BYTE_W-1:0] in_byte,
   input  logic                       advance,
   output logic                       s1_valid,
   output cpfd_pkg::frame_type        frame
);

   localparam logic [cpfd_pkg::IDX_W:0] DEPTH_C = (cpfd_pkg::IDX_W+1)'(BUFFER_DEPTH);

   logic                        s1_valid_ff, s1_valid_in;
   logic [cpfd_pkg::BYTE_W-1:0] s1_byte_ff;
   logic [cpfd_pkg::IDX_W-1:0]  index_ff, index_in;
   logic                        start_ff, start_in;
   logic [cpfd_pkg::BYTE_W-1:0] type_ff;
   logic [cpfd_pkg::BYTE_W-1:0] pay0_ff, pay1_ff, pay2_ff;

   logic [cpfd_pkg::IDX_W-1:0]  idx;
   logic [cpfd_pkg::IDX_W:0]    count;
   logic                        wrap;
   logic                        done;

   always_comb begin
      idx      = (s1_byte_ff == cpfd_pkg::CHAR_START) ? '0 : index_ff;
      start_in = (idx == '0) ? (s1_byte_ff == cpfd_pkg::CHAR_START) : start_ff;
      count    = {1'b0, idx} + 1'b1;
      wrap     = (count >= DEPTH_C);
      done     = !wrap && start_in &&
                 ({1'b0, cpfd_pkg::expected_length(type_ff)} == count);
      index_in = (done || wrap) ? '0 : count[cpfd_pkg::IDX_W-1:0];
   end

   assign s1_valid_in = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         index_ff    <= '0;
         start_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            index_ff <= index_in;
            start_ff <= start_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         s1_byte_ff <= in_byte;
      end
      if (advance) begin
         if (idx == cpfd_pkg::IDX_W'(1)) type_ff <= s1_byte_ff;
         if (idx == cpfd_pkg::IDX_W'(2)) pay0_ff <= s1_byte_ff;
         if (idx == cpfd_pkg::IDX_W'(3)) pay1_ff <= s1_byte_ff;
         if (idx == cpfd_pkg::IDX_W'(4)) pay2_ff <= s1_byte_ff;
      end
   end

   // Completion needs index >= 4, so type and payload come from stored bytes.
   assign s1_valid    = s1_valid_ff;
   assign frame.done  = done;
   assign frame.ptype = type_ff;
   assign frame.len   = count[cpfd_pkg::LEN_W-1:0];
   assign frame.pay0  = pay0_ff;
   assign frame.pay1  = pay1_ff;
   assign frame.pay2  = pay2_ff;

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, index_ff} < DEPTH_C)
      else $error("byte index beyond buffer depth");

   a_index_clears_on_done: assert property (@(posedge clock) disable iff (reset)
      (advance && done) |=> (index_ff == '0))
      else $error("index not cleared after completed packet");

endmodule

/* rtl/core/cpfd_decoder.sv */
// Decoder: colour and button registers plus the result register.
// Updates on completed C and B packets. Depends on cpfd_pkg.
module cpfd_decoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  cpfd_pkg::frame_type         frame,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_packet_valid,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_packet_type,
   output logic [cpfd_pkg::LEN_W-1:0]  rsp_packet_length,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_red,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_green,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_blue,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_button_flags
);

   logic                        out_valid_ff, out_valid_in;
   logic [cpfd_pkg::BYTE_W-1:0] red_ff, red_in;
   logic [cpfd_pkg::BYTE_W-1:0] green_ff, green_in;
   logic [cpfd_pkg::BYTE_W-1:0] blue_ff, blue_in;
   logic [cpfd_pkg::BYTE_W-1:0] button_ff, button_in;

   logic                        pvalid_ff;
   logic [cpfd_pkg::BYTE_W-1:0] ptype_ff;
   logic [cpfd_pkg::LEN_W-1:0]  plen_ff;
   logic [cpfd_pkg::BYTE_W-1:0] ored_ff, ogreen_ff, oblue_ff, obutton_ff;

   logic [cpfd_pkg::BYTE_W-1:0] num;
   logic [cpfd_pkg::BYTE_W-1:0] bit_mask;

   always_comb begin
      red_in    = red_ff;
      green_in  = green_ff;
      blue_in   = blue_ff;
      button_in = button_ff;
      num       = frame.pay0 - cpfd_pkg::CHAR_ZERO;
      bit_mask  = cpfd_pkg::BYTE_W'(1) << num[2:0] - 3'd1;
      if (frame.done) begin
         unique case (frame.ptype)
            cpfd_pkg::CHAR_C: begin
               red_in   = frame.pay0;
               green_in = frame.pay1;
               blue_in  = frame.pay2;
            end
            cpfd_pkg::CHAR_B: begin
               if (num >= cpfd_pkg::BYTE_W'(1) && num <= cpfd_pkg::BUTTON_MAX) begin
                  if (frame.pay1 != cpfd_pkg::CHAR_ZERO) button_in = button_ff | bit_mask;
                  else                                   button_in = button_ff & ~bit_mask;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && rsp_ready) ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         button_ff    <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            red_ff    <= red_in;
            green_ff  <= green_in;
            blue_ff   <= blue_in;
            button_ff <= button_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pvalid_ff  <= frame.done;
         ptype_ff   <= frame.done ? frame.ptype : '0;
         plen_ff    <= frame.done ? frame.len : '0;
         ored_ff    <= red_in;
         ogreen_ff  <= green_in;
         oblue_ff   <= blue_in;
         obutton_ff <= button_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_packet_valid  = pvalid_ff;
   assign rsp_packet_type   = ptype_ff;
   assign rsp_packet_length = plen_ff;
   assign rsp_color_red     = ored_ff;
   assign rsp_color_green   = ogreen_ff;
   assign rsp_color_blue    = oblue_ff;
   assign rsp_button_flags  = obutton_ff;

   a_result_matches_regs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_color_red == red_ff && rsp_button_flags == button_ff))
      else $error("result register out of step with state");

endmodule

/* rtl/core/controller_packet_framer_decoder.sv */
// Controller packet framer/decoder, top level. Instantiates cpfd_framer and cpfd_decoder.
// Path: an accepted item is held in the input register, then moves to the result register.
// Throughput: one item per cycle while rsp_ready is high; result register frees as it is taken.
// Reset: synchronous, active high; clears index, start flag, colour and button registers.
// Type/payload capture registers are not reset; they are always written before use.
module controller_packet_framer_decoder #(
   parameter int unsigned BUFFER_DEPTH = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [cpfd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_packet_valid,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_packet_type,
   output logic [cpfd_pkg::LEN_W-1:0]  rsp_packet_length,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_red,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_green,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_color_blue,
   output logic [cpfd_pkg::BYTE_W-1:0] rsp_button_flags
);

   logic                s1_valid;
   logic                advance;
   logic                in_take;
   cpfd_pkg::frame_type frame;

   assign advance   = s1_valid && (!rsp_valid || rsp_ready);
   assign req_ready = !s1_valid || advance;
   assign in_take   = req_valid && req_ready;

   cpfd_framer #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .in_take (in_take),
      .in_byte (req_rx_byte),
      .advance (advance),
      .s1_valid(s1_valid),
      .frame   (frame)
   );

   cpfd_decoder u_decoder (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .frame            (frame),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_packet_valid (rsp_packet_valid),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_packet_length(rsp_packet_length),
      .rsp_color_red    (rsp_color_red),
      .rsp_color_green  (rsp_color_green),
      .rsp_color_blue   (rsp_color_blue),
      .rsp_button_flags (rsp_button_flags)
   );

   a_valid_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_packet_valid) |-> (rsp_packet_length != '0))
      else $error("completed packet with zero length");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_packet_valid) |-> (rsp_packet_length == '0 && rsp_packet_type == '0))
      else $error("packet fields set without completion");

endmodule
